// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the timer manager RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define DTM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a property in the next
`define DTM_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hdl/dtm_pkg.sv =====
package dtm_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int SLOT_BITS  = 4;
   localparam int TICK_BITS  = 32;

   // command codes
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_CREATE = 3'd1;
   localparam logic [2:0] CMD_START  = 3'd2;
   localparam logic [2:0] CMD_STOP   = 3'd3;
   localparam logic [2:0] CMD_QUERY  = 3'd4;

   // slot modes
   localparam logic [2:0] MODE_INIT    = 3'd0;
   localparam logic [2:0] MODE_CREATED = 3'd1;
   localparam logic [2:0] MODE_RUNNING = 3'd2;
   localparam logic [2:0] MODE_STOPPED = 3'd3;

   // result kinds
   localparam logic [1:0] EV_REPLY     = 2'd0;
   localparam logic [1:0] EV_EXPIRED   = 2'd1;
   localparam logic [1:0] EV_TICK_DONE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_REINS
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } chain_op_type;

   typedef struct packed {
      logic                 valid;
      logic [TICK_BITS-1:0] deadline;
      logic [SLOT_BITS-1:0] slot;
   } entry_type;

   typedef struct packed {
      chain_op_type         op;
      logic [TICK_BITS-1:0] key;
      logic [SLOT_BITS-1:0] slot;
   } chain_ctl_type;

endpackage

// ===== hdl/sorted_deadline_timer_manager.sv =====
// Timer manager for 16 slots. Running slots sit in a row of cells sorted by
// deadline (head in cell 0); each insert or unlink shifts the whole row.
// Create, start, stop and query write their result from the execute state
// once the output register is free. A tick unlinks expired slots from the
// head and reinserts each periodic one from a separate state, as the row
// does one insert or unlink per cycle. Results wait in an output register,
// each holding its own tick value; the next item is taken once the current
// one has placed its last result there. No clearing pass after reset.
`include "assert_macros.svh"

module sorted_deadline_timer_manager (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_command,
   input  logic [dtm_pkg::SLOT_BITS-1:0]   req_timer_index,
   input  logic                            req_periodic,
   input  logic [31:0]                     req_period,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_event_kind,
   output logic [dtm_pkg::SLOT_BITS-1:0]   rsp_timer_index_res,
   output logic                            rsp_accepted,
   output logic [2:0]                      rsp_slot_state,
   output logic [31:0]                     rsp_remaining,
   output logic [31:0]                     rsp_current_tick,
   output logic                            rsp_last
);

   localparam int N  = dtm_pkg::NUM_TIMERS;
   localparam int SB = dtm_pkg::SLOT_BITS;
   localparam int TB = dtm_pkg::TICK_BITS;

   dtm_pkg::state_type state_ff, state_in;

   logic [2:0]    cmd_ff;
   logic [SB-1:0] idx_ff;
   logic          periodic_ff;
   logic [31:0]   period_arg_ff;
   logic [TB-1:0] tick_ff;
   logic [N-1:0]  seen_ff;
   logic [SB-1:0] rins_slot_ff;
   logic [TB-1:0] rins_dl_ff;

   // slot table
   logic [2:0]    mode_ff     [N];
   logic          is_per_ff   [N];
   logic [TB-1:0] per_ff      [N];
   logic [TB-1:0] dl_ff       [N];

   // output register
   logic          rsp_valid_ff;
   logic [1:0]    kind_ff;
   logic [SB-1:0] ridx_ff;
   logic          acc_ff;
   logic [2:0]    rmode_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   ctick_ff;
   logic          last_ff;

   // chain of cells
   dtm_pkg::chain_ctl_type ctl;
   dtm_pkg::entry_type     cell_q [N];
   logic [N-1:0]           shift_w, after_w;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         dtm_pkg::entry_type le, re;
         logic               ls, la;
         if (gi == 0) begin : g_first
            assign le = '0;
            assign ls = 1'b0;
            assign la = 1'b0;
         end else begin : g_mid
            assign le = cell_q[gi-1];
            assign ls = shift_w[gi-1];
            assign la = after_w[gi-1];
         end
         if (gi == N-1) begin : g_last
            assign re = '0;
         end else begin : g_nlast
            assign re = cell_q[gi+1];
         end
         dtm_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .left_entry  (le),
            .right_entry (re),
            .left_shift  (ls),
            .left_after  (la),
            .entry       (cell_q[gi]),
            .shift       (shift_w[gi]),
            .after       (after_w[gi])
         );
      end
   endgenerate

   dtm_pkg::entry_type head;
   logic [SB-1:0] addr;
   logic [2:0]    rd_mode;
   logic          rd_per_flag;
   logic [TB-1:0] rd_per, rd_dl, new_dl;
   logic          out_free, accept, emit, pop_go;
   logic          create_ok, start_ok, stop_go, tick_go;
   logic          tbl_expire;
   logic [1:0]    o_kind;
   logic [SB-1:0] o_idx;
   logic          o_acc, o_last;
   logic [2:0]    o_mode;
   logic [31:0]   o_rem;

   assign head        = cell_q[0];
   assign addr        = (state_ff == dtm_pkg::ST_POP) ? head.slot : idx_ff;
   assign rd_mode     = mode_ff[addr];
   assign rd_per_flag = is_per_ff[addr];
   assign rd_per      = per_ff[addr];
   assign rd_dl       = dl_ff[addr];
   assign new_dl      = tick_ff + rd_per;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != dtm_pkg::ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign tick_go     = accept && (req_command == dtm_pkg::CMD_TICK);
   assign pop_go      = head.valid && (head.deadline <= tick_ff) && !seen_ff[head.slot];

   // sequencer: next state, chain operation and result fields
   always_comb begin
      state_in   = state_ff;
      ctl        = '{op: dtm_pkg::OP_HOLD, key: '0, slot: '0};
      emit       = 1'b0;
      create_ok  = 1'b0;
      start_ok   = 1'b0;
      stop_go    = 1'b0;
      tbl_expire = 1'b0;
      o_kind     = dtm_pkg::EV_REPLY;
      o_idx      = idx_ff;
      o_acc      = 1'b0;
      o_mode     = rd_mode;
      o_rem      = '0;
      o_last     = 1'b1;
      unique case (state_ff)
         dtm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == dtm_pkg::CMD_TICK) state_in = dtm_pkg::ST_POP;
               else                                  state_in = dtm_pkg::ST_EXEC;
            end
         end
         dtm_pkg::ST_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = dtm_pkg::ST_IDLE;
               case (cmd_ff)
                  dtm_pkg::CMD_CREATE: begin
                     create_ok = (rd_mode == dtm_pkg::MODE_INIT) && (period_arg_ff != '0);
                     o_acc     = create_ok;
                     if (create_ok) o_mode = dtm_pkg::MODE_CREATED;
                  end
                  dtm_pkg::CMD_START: begin
                     start_ok = (rd_mode == dtm_pkg::MODE_CREATED) ||
                                (rd_mode == dtm_pkg::MODE_STOPPED);
                     o_acc    = start_ok;
                     if (start_ok) begin
                        o_mode = dtm_pkg::MODE_RUNNING;
                        ctl    = '{op: dtm_pkg::OP_INSERT, key: new_dl, slot: idx_ff};
                     end
                  end
                  dtm_pkg::CMD_STOP: begin
                     stop_go = 1'b1;
                     o_acc   = 1'b1;
                     o_mode  = dtm_pkg::MODE_STOPPED;
                     if (rd_mode == dtm_pkg::MODE_RUNNING)
                        ctl = '{op: dtm_pkg::OP_REMOVE, key: '0, slot: idx_ff};
                  end
                  dtm_pkg::CMD_QUERY: begin
                     o_acc = 1'b1;
                     o_rem = 32'(rd_dl - tick_ff);
                  end
                  default: o_acc = 1'b0;
               endcase
            end
         end
         dtm_pkg::ST_POP: begin
            if (out_free) begin
               emit = 1'b1;
               if (pop_go) begin
                  tbl_expire = 1'b1;
                  o_kind     = dtm_pkg::EV_EXPIRED;
                  o_idx      = head.slot;
                  o_last     = 1'b0;
                  o_mode     = rd_per_flag ? dtm_pkg::MODE_RUNNING : dtm_pkg::MODE_STOPPED;
                  ctl        = '{op: dtm_pkg::OP_REMOVE, key: '0, slot: head.slot};
                  if (rd_per_flag) state_in = dtm_pkg::ST_REINS;
               end else begin
                  o_kind   = dtm_pkg::EV_TICK_DONE;
                  o_idx    = '0;
                  o_mode   = dtm_pkg::MODE_INIT;
                  state_in = dtm_pkg::ST_IDLE;
               end
            end
         end
         dtm_pkg::ST_REINS: begin
            ctl      = '{op: dtm_pkg::OP_INSERT, key: rins_dl_ff, slot: rins_slot_ff};
            state_in = dtm_pkg::ST_POP;
         end
         default: state_in = dtm_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtm_pkg::ST_IDLE;
         tick_ff      <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (tick_go) begin
            tick_ff <= tick_ff + TB'(1);
            seen_ff <= '0;
         end else if (tbl_expire) begin
            seen_ff[head.slot] <= 1'b1;
         end
         if (emit)          rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // latched command, relink data and result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_command;
         idx_ff        <= req_timer_index;
         periodic_ff   <= req_periodic;
         period_arg_ff <= req_period;
      end
      if (tbl_expire) begin
         rins_slot_ff <= head.slot;
         rins_dl_ff   <= new_dl;
      end
      if (emit) begin
         kind_ff  <= o_kind;
         ridx_ff  <= o_idx;
         acc_ff   <= o_acc;
         rmode_ff <= o_mode;
         rem_ff   <= o_rem;
         ctick_ff <= tick_ff[31:0];
         last_ff  <= o_last;
      end
   end

   // slot table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            mode_ff[i]   <= dtm_pkg::MODE_INIT;
            is_per_ff[i] <= 1'b0;
            per_ff[i]    <= '0;
            dl_ff[i]     <= '0;
         end
      end else begin
         if (create_ok) begin
            mode_ff[addr]   <= dtm_pkg::MODE_CREATED;
            is_per_ff[addr] <= periodic_ff;
            per_ff[addr]    <= TB'(period_arg_ff);
            dl_ff[addr]     <= '0;
         end
         if (start_ok) begin
            mode_ff[addr] <= dtm_pkg::MODE_RUNNING;
            dl_ff[addr]   <= new_dl;
         end
         if (stop_go) mode_ff[addr] <= dtm_pkg::MODE_STOPPED;
         if (tbl_expire) begin
            mode_ff[addr] <= rd_per_flag ? dtm_pkg::MODE_RUNNING : dtm_pkg::MODE_STOPPED;
            if (rd_per_flag) dl_ff[addr] <= new_dl;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = kind_ff;
   assign rsp_timer_index_res = ridx_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_slot_state      = rmode_ff;
   assign rsp_remaining       = rem_ff;
   assign rsp_current_tick    = ctick_ff;
   assign rsp_last            = last_ff;

   // row stays sorted with its entries packed towards the head
   generate
      for (gi = 0; gi < N-1; gi++) begin : g_chk
         `DTM_ASSERT(a_sorted, !(cell_q[gi].valid && cell_q[gi+1].valid) || (cell_q[gi].deadline <= cell_q[gi+1].deadline), "cell row out of order")
         `DTM_ASSERT(a_packed, cell_q[gi].valid || !cell_q[gi+1].valid, "gap in cell row")
      end
   endgenerate

   `DTM_ASSERT_NEXT(a_tick_step, tick_go, tick_ff == $past(tick_ff) + TB'(1), "tick not advanced")
   `DTM_ASSERT(a_done_last, !(rsp_valid_ff && kind_ff == dtm_pkg::EV_TICK_DONE) || last_ff, "tick done without last")

endmodule

// ===== hdl/dtm_cell.sv =====
module dtm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dtm_pkg::chain_ctl_type ctl,
   input  dtm_pkg::entry_type     left_entry,
   input  dtm_pkg::entry_type     right_entry,
   input  logic                   left_shift,
   input  logic                   left_after,
   output dtm_pkg::entry_type     entry,
   output logic                   shift,
   output logic                   after
);

   dtm_pkg::entry_type entry_ff, entry_in;

   // at or past the insertion point: empty, or deadline not below the key
   assign shift = !entry_ff.valid || (entry_ff.deadline >= ctl.key);
   // at or past the entry being unlinked
   assign after = left_after || (entry_ff.valid && entry_ff.slot == ctl.slot);
   assign entry = entry_ff;

   // next content: hold, shift right on insert, shift left on removal
   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         dtm_pkg::OP_INSERT: begin
            if (shift) begin
               if (left_shift) entry_in = left_entry;
               else            entry_in = '{valid: 1'b1, deadline: ctl.key, slot: ctl.slot};
            end
         end
         dtm_pkg::OP_REMOVE: begin
            if (after) entry_in = right_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff <= '0;
      else       entry_ff <= entry_in;
   end

endmodule
